/* rtl/tec_pkg.sv */
package tec_pkg;

    // field widths
    localparam int COORD_BITS  = 12;
    localparam int EXTENT_W    = COORD_BITS + 1;
    localparam int SAMPLE_W    = 16;
    localparam int EDGE_LIMIT  = 65535;

    // arithmetic widths
    localparam int PROD_W      = SAMPLE_W + EXTENT_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int BITS_PER_ST = 4;
    localparam int DIV_W       = ((NUM_W + BITS_PER_ST - 1) / BITS_PER_ST) * BITS_PER_ST;
    localparam int ACC_W       = COORD_BITS + DIV_W;
    localparam int EDGE_CALC_W = DIV_W + 2;

    // pipeline depth
    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = DIV_W / BITS_PER_ST;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + 1;

    // stream packing
    localparam int IN_FIELDS_W = 4 * SAMPLE_W + 2 * COORD_BITS + EXTENT_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 2 * SAMPLE_W;

    // data carried alongside the division
    typedef struct packed {
        logic                reject;
        logic                hi_neg;
        logic [SAMPLE_W-1:0] near_avg;
        logic [SAMPLE_W-1:0] far_avg;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0]      num_lo;
        logic [NUM_W-1:0]      num_hi;
        logic [COORD_BITS-1:0] divisor;
        t_side                 side;
    } t_div_req;

    typedef struct packed {
        logic [DIV_W-1:0] q_lo;
        logic [DIV_W-1:0] q_hi;
        t_side            side;
    } t_div_rsp;

endpackage

/* rtl/tec_front.sv */
module tec_front
    import tec_pkg::*;
(
    input  logic                    i_clk,
    input  logic [FRONT_STAGES-1:0] i_en,
    input  logic [SAMPLE_W-1:0]     i_near_a,
    input  logic [SAMPLE_W-1:0]     i_near_b,
    input  logic [SAMPLE_W-1:0]     i_far_a,
    input  logic [SAMPLE_W-1:0]     i_far_b,
    input  logic [COORD_BITS-1:0]   i_near_point,
    input  logic [COORD_BITS-1:0]   i_far_point,
    input  logic [EXTENT_W-1:0]     i_extent,
    output t_div_req                o_req
);

    // stage a: averages, spans, offset to the last pixel
    logic [SAMPLE_W:0]     n_sum_near;
    logic [SAMPLE_W:0]     n_sum_far;
    logic [SAMPLE_W-1:0]   n_near_avg;
    logic [SAMPLE_W-1:0]   n_far_avg;
    logic [COORD_BITS:0]   n_tdiff;
    logic [SAMPLE_W:0]     n_rdiff;
    logic [COORD_BITS+1:0] n_off;
    logic [COORD_BITS+1:0] n_off_abs;
    logic                  n_reject;

    logic [SAMPLE_W-1:0]   r_a_rspan;
    logic [COORD_BITS-1:0] r_a_tspan;
    logic [COORD_BITS-1:0] r_a_np;
    logic [EXTENT_W-1:0]   r_a_off;
    logic                  r_a_off_neg;
    t_side                 r_a_side;

    always_comb begin
        n_sum_near = {1'b0, i_near_a} + {1'b0, i_near_b} + {{SAMPLE_W{1'b0}}, 1'b1};
        n_sum_far  = {1'b0, i_far_a} + {1'b0, i_far_b} + {{SAMPLE_W{1'b0}}, 1'b1};
        n_near_avg = n_sum_near[SAMPLE_W:1];
        n_far_avg  = n_sum_far[SAMPLE_W:1];
        n_tdiff    = {1'b0, i_far_point} - {1'b0, i_near_point};
        n_rdiff    = {1'b0, n_far_avg} - {1'b0, n_near_avg};
        n_off      = {1'b0, i_extent} - {{(COORD_BITS+1){1'b0}}, 1'b1}
                     - {2'b00, i_far_point};
        n_off_abs  = n_off[COORD_BITS+1] ? (~n_off + {{(COORD_BITS+1){1'b0}}, 1'b1}) : n_off;
        n_reject   = n_tdiff[COORD_BITS] || (n_tdiff == '0)
                     || n_rdiff[SAMPLE_W] || (n_rdiff == '0)
                     || (i_extent <= {{(EXTENT_W-1){1'b0}}, 1'b1});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_rspan          <= n_rdiff[SAMPLE_W-1:0];
            r_a_tspan          <= n_tdiff[COORD_BITS-1:0];
            r_a_np             <= i_near_point;
            r_a_off            <= n_off_abs[EXTENT_W-1:0];
            r_a_off_neg        <= n_off[COORD_BITS+1];
            r_a_side.reject    <= n_reject;
            r_a_side.hi_neg    <= 1'b0;
            r_a_side.near_avg  <= n_near_avg;
            r_a_side.far_avg   <= n_far_avg;
        end
    end

    // stage b: the two span products
    logic [PROD_W-1:0]     r_b_prod_lo;
    logic [PROD_W-1:0]     r_b_prod_hi;
    logic [COORD_BITS-1:0] r_b_tspan;
    logic                  r_b_off_neg;
    t_side                 r_b_side;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_prod_lo <= PROD_W'(r_a_rspan) * PROD_W'(r_a_np);
            r_b_prod_hi <= PROD_W'(r_a_rspan) * PROD_W'(r_a_off);
            r_b_tspan   <= r_a_tspan;
            r_b_off_neg <= r_a_off_neg;
            r_b_side    <= r_a_side;
        end
    end

    // stage c: add the half-span bias, split the high numerator into sign and magnitude
    logic [NUM_W-1:0] n_half;
    logic [NUM_W-1:0] n_plo;
    logic [NUM_W-1:0] n_phi;
    logic [NUM_W-1:0] n_num_hi;
    logic             n_hi_neg;
    t_side            n_side;

    always_comb begin
        n_half = NUM_W'(r_b_tspan >> 1);
        n_plo  = NUM_W'(r_b_prod_lo);
        n_phi  = NUM_W'(r_b_prod_hi);
        if (!r_b_off_neg) begin
            n_num_hi = n_phi + n_half;
            n_hi_neg = 1'b0;
        end else if (n_phi > n_half) begin
            n_num_hi = n_phi - n_half;
            n_hi_neg = 1'b1;
        end else begin
            n_num_hi = n_half - n_phi;
            n_hi_neg = 1'b0;
        end
        n_side        = r_b_side;
        n_side.hi_neg = n_hi_neg;
    end

    t_div_req r_c_req;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_c_req.num_lo  <= n_plo + n_half;
            r_c_req.num_hi  <= n_num_hi;
            r_c_req.divisor <= r_b_tspan;
            r_c_req.side    <= n_side;
        end
    end

    assign o_req = r_c_req;

endmodule

/* rtl/tec_div.sv */
module tec_div
    import tec_pkg::*;
(
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  t_div_req              i_req,
    output t_div_rsp              o_rsp
);

    // one restoring step: shift in the next dividend bit, subtract when it fits
    function automatic logic [ACC_W-1:0] div_step(
        input logic [ACC_W-1:0]      acc,
        input logic [COORD_BITS-1:0] d
    );
        logic [COORD_BITS:0] trial;
        logic [COORD_BITS:0] diff;
        logic                fits;
        trial = acc[ACC_W-1:DIV_W-1];
        diff  = trial - {1'b0, d};
        fits  = (trial >= {1'b0, d});
        return {(fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0]),
                acc[DIV_W-2:0], fits};
    endfunction

    logic [ACC_W-1:0]      r_acc_lo [DIV_STAGES];
    logic [ACC_W-1:0]      r_acc_hi [DIV_STAGES];
    logic [COORD_BITS-1:0] r_dvs    [DIV_STAGES];
    t_side                 r_side   [DIV_STAGES];

    // each stage retires four quotient bits of both lanes
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [ACC_W-1:0]      w_lo_in;
        logic [ACC_W-1:0]      w_hi_in;
        logic [COORD_BITS-1:0] w_dvs_in;
        t_side                 w_side_in;
        logic [ACC_W-1:0]      n_lo;
        logic [ACC_W-1:0]      n_hi;

        if (s == 0) begin : g_first
            assign w_lo_in   = ACC_W'(i_req.num_lo);
            assign w_hi_in   = ACC_W'(i_req.num_hi);
            assign w_dvs_in  = i_req.divisor;
            assign w_side_in = i_req.side;
        end else begin : g_next
            assign w_lo_in   = r_acc_lo[s-1];
            assign w_hi_in   = r_acc_hi[s-1];
            assign w_dvs_in  = r_dvs[s-1];
            assign w_side_in = r_side[s-1];
        end

        always_comb begin
            n_lo = w_lo_in;
            n_hi = w_hi_in;
            for (int k = 0; k < BITS_PER_ST; k++) begin
                n_lo = div_step(n_lo, w_dvs_in);
                n_hi = div_step(n_hi, w_dvs_in);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_acc_lo[s] <= n_lo;
                r_acc_hi[s] <= n_hi;
                r_dvs[s]    <= w_dvs_in;
                r_side[s]   <= w_side_in;
            end
        end
    end

    assign o_rsp.q_lo = r_acc_lo[DIV_STAGES-1][DIV_W-1:0];
    assign o_rsp.q_hi = r_acc_hi[DIV_STAGES-1][DIV_W-1:0];
    assign o_rsp.side = r_side[DIV_STAGES-1];

endmodule

/* rtl/tec_back.sv */
module tec_back
    import tec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  t_div_rsp            i_rsp,
    output logic                o_bounds_ok,
    output logic [SAMPLE_W-1:0] o_low_edge,
    output logic [SAMPLE_W-1:0] o_high_edge
);

    // saturate a signed edge to the sample range
    function automatic logic [SAMPLE_W-1:0] clamp_edge(input logic [EDGE_CALC_W-1:0] v);
        logic [SAMPLE_W-1:0] res;
        if (v[EDGE_CALC_W-1]) begin
            res = '0;
        end else if (v > EDGE_CALC_W'(EDGE_LIMIT)) begin
            res = SAMPLE_W'(EDGE_LIMIT);
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    logic [EDGE_CALC_W-1:0] n_lo;
    logic [EDGE_CALC_W-1:0] n_hi;
    logic [SAMPLE_W-1:0]    n_lo_c;
    logic [SAMPLE_W-1:0]    n_hi_c;
    logic                   n_ok;

    // apply the quotients, clamp and check ordering
    always_comb begin
        n_lo = EDGE_CALC_W'(i_rsp.side.near_avg) - EDGE_CALC_W'(i_rsp.q_lo);
        if (i_rsp.side.hi_neg) begin
            n_hi = EDGE_CALC_W'(i_rsp.side.far_avg) - EDGE_CALC_W'(i_rsp.q_hi);
        end else begin
            n_hi = EDGE_CALC_W'(i_rsp.side.far_avg) + EDGE_CALC_W'(i_rsp.q_hi);
        end
        n_lo_c = clamp_edge(n_lo);
        n_hi_c = clamp_edge(n_hi);
        n_ok   = !i_rsp.side.reject && (n_lo_c < n_hi_c);
    end

    logic                r_ok;
    logic [SAMPLE_W-1:0] r_low;
    logic [SAMPLE_W-1:0] r_high;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok   <= n_ok;
            r_low  <= n_ok ? n_lo_c : '0;
            r_high <= n_ok ? n_hi_c : '0;
        end
    end

    assign o_bounds_ok = r_ok;
    assign o_low_edge  = r_low;
    assign o_high_edge = r_high;

endmodule

/* rtl/touch_axis_edge_extrapolation.sv */
// Two-point touch calibration for one screen axis.
// The slave stream carries one request per beat: two raw samples at the near
// target, two at the far target, both target pixels and the screen extent.
// The master stream returns one result per request, in order: the raw reading
// extrapolated to pixel zero and to the last pixel, and a flag in tuser that
// is low when the calibration is rejected (both edges then read zero).
// From acceptance to tvalid on the master side a request passes three
// front stages (averages and spans, the span multipliers, bias and sign), eight
// stages of the pipelined divider with four quotient bits each, and the output
// register that clamps and checks the edges.
// Throughput is one request per cycle while the receiver does not stall.
// Each stage moves on whenever it is empty or the stage after it moves, so
// bubbles are squeezed out and new requests are taken while a result waits.
// When the receiver stalls, results pile up until every stage holds one; only
// then does tready drop. Nothing is lost or repeated.
// Reset clears the valid bits of all stages; data registers are not reset.
module touch_axis_edge_extrapolation
    import tec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // first_near_sample, second_near_sample, first_far_sample, second_far_sample,
    // near_point, far_point, screen_extent, zero padding
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // low_edge, high_edge
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // bounds_ok
    output logic                  o_m_axis_tuser
);

    localparam int P_NA = 0;
    localparam int P_NB = P_NA + SAMPLE_W;
    localparam int P_FA = P_NB + SAMPLE_W;
    localparam int P_FB = P_FA + SAMPLE_W;
    localparam int P_NP = P_FB + SAMPLE_W;
    localparam int P_FP = P_NP + COORD_BITS;
    localparam int P_EX = P_FP + COORD_BITS;

    logic [PIPE_DEPTH-1:0] r_v;
    logic [PIPE_DEPTH-1:0] w_en;

    // stage enables: a stage loads when it is empty or its successor loads
    always_comb begin
        w_en[PIPE_DEPTH-1] = !r_v[PIPE_DEPTH-1] || i_m_axis_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    // valid bits travelling with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= (i == 0) ? i_s_axis_tvalid : r_v[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    t_div_req w_req;
    t_div_rsp w_rsp;

    tec_front u_front (
        .i_clk        (i_clk),
        .i_en         (w_en[FRONT_STAGES-1:0]),
        .i_near_a     (i_s_axis_tdata[P_NA +: SAMPLE_W]),
        .i_near_b     (i_s_axis_tdata[P_NB +: SAMPLE_W]),
        .i_far_a      (i_s_axis_tdata[P_FA +: SAMPLE_W]),
        .i_far_b      (i_s_axis_tdata[P_FB +: SAMPLE_W]),
        .i_near_point (i_s_axis_tdata[P_NP +: COORD_BITS]),
        .i_far_point  (i_s_axis_tdata[P_FP +: COORD_BITS]),
        .i_extent     (i_s_axis_tdata[P_EX +: EXTENT_W]),
        .o_req        (w_req)
    );

    tec_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en[FRONT_STAGES +: DIV_STAGES]),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    logic [SAMPLE_W-1:0] w_low;
    logic [SAMPLE_W-1:0] w_high;

    tec_back u_back (
        .i_clk       (i_clk),
        .i_en        (w_en[PIPE_DEPTH-1]),
        .i_rsp       (w_rsp),
        .o_bounds_ok (o_m_axis_tuser),
        .o_low_edge  (w_low),
        .o_high_edge (w_high)
    );

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_v[PIPE_DEPTH-1];
    assign o_m_axis_tdata  = {w_high, w_low};

endmodule

/* bench/touch_axis_edge_extrapolation_tb.sv */
`timescale 1ns / 1ps

module touch_axis_edge_extrapolation_tb;
    import tec_pkg::*;

    // one calibration request, first field in the lowest bits
    typedef struct packed {
        logic [EXTENT_W-1:0]   extent;
        logic [COORD_BITS-1:0] far_pt;
        logic [COORD_BITS-1:0] near_pt;
        logic [SAMPLE_W-1:0]   second_far;
        logic [SAMPLE_W-1:0]   first_far;
        logic [SAMPLE_W-1:0]   second_near;
        logic [SAMPLE_W-1:0]   first_near;
    } cal_request_t;

    // edges as carried on the master side, plus the flag from tuser
    typedef struct packed {
        logic                bounds_ok;
        logic [SAMPLE_W-1:0] high_edge;
        logic [SAMPLE_W-1:0] low_edge;
    } edge_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // first_near_sample, second_near_sample, first_far_sample, second_far_sample,
    // near_point, far_point, screen_extent, zero padding
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // low_edge, high_edge
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // bounds_ok
    logic                  o_m_axis_tuser;

    edge_result_t pending_edges[$];
    int           mismatch_count;
    bit           src_gaps_on;
    bit           sink_gaps_on;
    int           sink_hold_cycles;

    touch_axis_edge_extrapolation dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // known values on every input from time zero
    initial begin
        i_rst_n          = 1'b0;
        i_s_axis_tvalid  = 1'b0;
        i_s_axis_tdata   = '0;
        i_m_axis_tready  = 1'b0;
        mismatch_count   = 0;
        src_gaps_on      = 1'b0;
        sink_gaps_on     = 1'b0;
        sink_hold_cycles = 0;
    end

    // expected edges: averages, spans, biased division toward zero, clamp, order check
    function automatic edge_result_t extrapolate_edges(input cal_request_t r);
        longint na, nb, fa, fb, np, fp, ext;
        longint near_avg, far_avg, tspan, rspan, half, lo, hi;
        edge_result_t res;
        na  = r.first_near;
        nb  = r.second_near;
        fa  = r.first_far;
        fb  = r.second_far;
        np  = r.near_pt;
        fp  = r.far_pt;
        ext = r.extent;
        res = '0;
        near_avg = (na + nb + 1) / 2;
        far_avg  = (fa + fb + 1) / 2;
        tspan    = fp - np;
        rspan    = far_avg - near_avg;
        if (tspan <= 0 || rspan <= 0 || ext <= 1) begin
            return res;
        end
        half = tspan / 2;
        lo   = near_avg - (rspan * np + half) / tspan;
        hi   = far_avg + (rspan * (ext - 1 - fp) + half) / tspan;
        if (lo < 0) begin
            lo = 0;
        end else if (lo > EDGE_LIMIT) begin
            lo = EDGE_LIMIT;
        end
        if (hi < 0) begin
            hi = 0;
        end else if (hi > EDGE_LIMIT) begin
            hi = EDGE_LIMIT;
        end
        if (lo >= hi) begin
            return res;
        end
        res.bounds_ok = 1'b1;
        res.low_edge  = lo[SAMPLE_W-1:0];
        res.high_edge = hi[SAMPLE_W-1:0];
        return res;
    endfunction

    function automatic cal_request_t make_request(input int unsigned fn, input int unsigned sn,
                                                  input int unsigned ff, input int unsigned sf,
                                                  input int unsigned np, input int unsigned fp,
                                                  input int unsigned ext);
        cal_request_t r;
        r.first_near  = SAMPLE_W'(fn);
        r.second_near = SAMPLE_W'(sn);
        r.first_far   = SAMPLE_W'(ff);
        r.second_far  = SAMPLE_W'(sf);
        r.near_pt     = COORD_BITS'(np);
        r.far_pt      = COORD_BITS'(fp);
        r.extent      = EXTENT_W'(ext);
        return r;
    endfunction

    // plausible calibration: targets ordered, far readings above near ones
    function automatic cal_request_t plausible_request();
        int unsigned ext, np, fp, fp_max, near_a, far_a;
        cal_request_t r;
        ext    = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096) : $urandom_range(2, 800);
        np     = $urandom_range(0, (ext - 1) / 3);
        fp_max = (ext - 1 > 4095) ? 4095 : ext - 1;
        // now and then the far target lies beyond the screen
        fp     = ($urandom_range(0, 7) == 0) ? $urandom_range(np + 1, 4095)
                                             : $urandom_range(np + 1, fp_max);
        near_a = $urandom_range(0, 40000);
        far_a  = $urandom_range(near_a + 16, 65520);
        r = make_request(near_a, near_a + $urandom_range(0, 15),
                         far_a, far_a + $urandom_range(0, 15), np, fp, ext);
        if ($urandom_range(0, 1) == 1) begin
            {r.first_near, r.second_near} = {r.second_near, r.first_near};
        end
        if ($urandom_range(0, 1) == 1) begin
            {r.first_far, r.second_far} = {r.second_far, r.first_far};
        end
        return r;
    endfunction

    // any bit pattern at all
    function automatic cal_request_t noise_request();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return cal_request_t'(bits[$bits(cal_request_t)-1:0]);
    endfunction

    // a plausible request with one thing spoilt
    function automatic cal_request_t broken_request();
        cal_request_t r;
        r = plausible_request();
        case ($urandom_range(0, 3))
            0: begin
                {r.near_pt, r.far_pt} = {r.far_pt, r.near_pt};
            end
            1: begin
                {r.first_near, r.second_near, r.first_far, r.second_far} =
                    {r.first_far, r.second_far, r.first_near, r.second_near};
            end
            2: begin
                r.extent = EXTENT_W'($urandom_range(0, 1));
            end
            default: begin
                r.far_pt = r.near_pt;
            end
        endcase
        return r;
    endfunction

    // send one request; returns at the edge where it was taken, or after a random gap when source gaps are on
    task automatic send_request(input cal_request_t r);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'(r);
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_edges.push_back(extrapolate_edges(r));
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    // receiver: random stall bursts, plus a long hold-off on demand
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end else if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 15);
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        edge_result_t got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tuser, o_m_axis_tdata};
            if (pending_edges.size() == 0) begin
                $display("%0t: result with no request pending: ok=%0b low=%0d high=%0d",
                         $time, got.bounds_ok, got.low_edge, got.high_edge);
                mismatch_count++;
            end else begin
                want = pending_edges.pop_front();
                if (got.bounds_ok !== want.bounds_ok || got.low_edge !== want.low_edge ||
                    got.high_edge !== want.high_edge) begin
                    $display("%0t: edge mismatch, expected ok=%0b low=%0d high=%0d, got ok=%0b low=%0d high=%0d",
                             $time, want.bounds_ok, want.low_edge, want.high_edge,
                             got.bounds_ok, got.low_edge, got.high_edge);
                    mismatch_count++;
                end
            end
        end
    end

    // extremes of the fields and each rejection path
    task automatic test_directed_edges();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        // all zero: no target span
        send_request(make_request(0, 0, 0, 0, 0, 0, 0));
        // ordinary calibration
        send_request(make_request(1000, 1001, 60000, 60001, 20, 300, 320));
        // averages round up
        send_request(make_request(0, 1, 40000, 40001, 10, 200, 240));
        // full raw and pixel range
        send_request(make_request(0, 0, 65535, 65535, 0, 4095, 4096));
        // raw span zero
        send_request(make_request(65535, 65535, 65535, 65535, 0, 4095, 4096));
        // far target before near target
        send_request(make_request(1000, 1000, 50000, 50000, 300, 20, 320));
        // raw span negative
        send_request(make_request(50000, 50001, 1000, 1001, 20, 300, 320));
        // extent zero and one
        send_request(make_request(1000, 1000, 50000, 50000, 0, 1, 0));
        send_request(make_request(1000, 1000, 50000, 50000, 0, 1, 1));
        // smallest usable extent
        send_request(make_request(1000, 1000, 50000, 50000, 0, 1, 2));
        // far target beyond the extent, negative numerator
        send_request(make_request(20000, 20001, 30000, 30003, 10, 500, 100));
        send_request(make_request(60000, 60000, 60010, 60010, 0, 4095, 2));
        // both edges clamp outward
        send_request(make_request(100, 100, 60000, 60000, 1000, 1010, 2000));
        // both edges clamp to zero, so not ordered
        send_request(make_request(0, 0, 100, 100, 10, 20, 2));
        // high edge saturates
        send_request(make_request(65000, 65000, 65535, 65535, 0, 1, 4096));
        // largest near target
        send_request(make_request(10, 20, 65535, 65534, 4094, 4095, 4096));
        // extent field at its maximum
        send_request(make_request(1, 2, 3, 4, 1, 2, 8191));
        // every bit set
        send_request(make_request(65535, 65535, 65535, 65535, 4095, 4095, 8191));
        wait_results_drained();
    endtask

    // receiver holds off until the pipeline fills and the input stalls
    task automatic test_backpressure_fill();
        src_gaps_on      = 1'b0;
        sink_gaps_on     = 1'b0;
        sink_hold_cycles = 80;
        repeat (40) send_request(plausible_request());
        wait_results_drained();
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_drain_pause();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        repeat (20) send_request(plausible_request());
        wait_results_drained();
        repeat (20) send_request(plausible_request());
        wait_results_drained();
    endtask

    // mostly plausible calibrations, some noise and spoilt requests
    task automatic test_random_stream();
        int unsigned pick;
        for (int seg = 0; seg < 8; seg++) begin
            src_gaps_on  = (seg != 7) && (seg % 3 != 2);
            sink_gaps_on = (seg != 7) && (seg % 3 != 1);
            for (int n = 0; n < 200; n++) begin
                pick = $urandom_range(0, 7);
                if (pick < 5) begin
                    send_request(plausible_request());
                end else if (pick < 7) begin
                    send_request(noise_request());
                end else begin
                    send_request(broken_request());
                end
            end
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_backpressure_fill();
        test_drain_pause();
        test_random_stream();
        if (mismatch_count == 0) begin
            $display("touch_axis_edge_extrapolation_tb OK");
        end else begin
            $display("touch_axis_edge_extrapolation_tb NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("touch_axis_edge_extrapolation_tb NOT OK");
        $finish;
    end

endmodule
